// ----- rtl/core/rcsac_pkg.sv -----
package rcsac_pkg;

    // Field widths
    localparam int RAW_W  = 11;
    localparam int CMD_W  = 11;
    localparam int DB_W   = 10;
    localparam int SLEW_W = 11;
    localparam int AGE_BITS = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Mapping arithmetic: |raw - center| * 1000 fits 21 bits, quotient below 1024 fits 10
    localparam int PROD_W    = 21;
    localparam int QUO_W     = 10;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = 4;

    localparam logic [QUO_W-1:0]    CMD_FULL = 10'd1000;
    localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};
    localparam logic [AGE_BITS-1:0] MODE_STALE_TICKS = 8'd10;

    typedef logic [1:0] op_t;
    localparam op_t OP_FRAME = 2'd0;
    localparam op_t OP_MODE  = 2'd1;
    localparam op_t OP_TICK  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_RAW_MIN     = 3'd0;
    localparam cfg_idx_t REG_RAW_CENTER  = 3'd1;
    localparam cfg_idx_t REG_RAW_MAX     = 3'd2;
    localparam cfg_idx_t REG_FWD_DB      = 3'd3;
    localparam cfg_idx_t REG_YAW_DB      = 3'd4;
    localparam cfg_idx_t REG_INVERT      = 3'd5;
    localparam cfg_idx_t REG_SLEW        = 3'd6;
    localparam cfg_idx_t REG_STALE_TICKS = 3'd7;

    // Register values after reset
    localparam logic [RAW_W-1:0]    RST_RAW_MIN     = 11'd191;
    localparam logic [RAW_W-1:0]    RST_RAW_CENTER  = 11'd997;
    localparam logic [RAW_W-1:0]    RST_RAW_MAX     = 11'd1792;
    localparam logic [DB_W-1:0]     RST_FWD_DB      = 10'd150;
    localparam logic [DB_W-1:0]     RST_YAW_DB      = 10'd40;
    localparam logic [1:0]          RST_INVERT      = 2'd0;
    localparam logic [SLEW_W-1:0]   RST_SLEW        = 11'd0;
    localparam logic [AGE_BITS-1:0] RST_STALE_TICKS = 8'd8;

endpackage

// ----- rtl/core/rc_stick_axis_conditioner_core.sv -----
// Channel  | Direction | Payload
// s_axis   | in        | tuser: op[1:0]; tdata: fwd_raw, yaw_raw, frame_ok, mode_manual
// m_axis   | out       | tuser: axes_stale; tdata: fwd_cmd, yaw_cmd
// cfg      | in        | cfg_wr_en, cfg_addr, cfg_wr_data (write only)
//
// Channel frames and mode updates are handled in ST_IDLE without leaving it.
// A fresh manual mode and fresh axes run ST_CALC, ST_CHK, ST_DIV and ST_POST per axis:
// both axes share one restoring divider, 10 steps each, skipped when the quotient overflows.
// A tick with stale axes skips to ST_SLEW; one without a fresh manual mode emits no word.
// ST_SLEW, the last step, waits while the output register still holds an untaken word.
// aresetn is synchronous, active low; it clears state and loads register defaults.
module rc_stick_axis_conditioner_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // fwd_raw[10:0], yaw_raw[21:11], frame_ok[22], mode_manual[23]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // fwd_cmd[10:0], yaw_cmd[21:11], zero[23:22]
    output logic        m_axis_tuser,   // axes_stale[0]
    input  logic        cfg_wr_en,
    input  logic [rcsac_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rcsac_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_CHK,
        ST_DIV,
        ST_POST,
        ST_SLEW
    } state_t;

    state_t state_reg;

    // Configuration
    logic [rcsac_pkg::RAW_W-1:0]    raw_min_reg, raw_center_reg, raw_max_reg;
    logic [rcsac_pkg::DB_W-1:0]     fwd_db_reg, yaw_db_reg;
    logic [1:0]                     invert_reg;
    logic [rcsac_pkg::SLEW_W-1:0]   slew_reg;
    logic [rcsac_pkg::AGE_BITS-1:0] stale_ticks_reg;

    // Tracking state
    logic [rcsac_pkg::RAW_W-1:0]    fwd_sample_reg, yaw_sample_reg;
    logic                           frame_valid_reg, mode_manual_reg, mode_seen_reg;
    logic [rcsac_pkg::AGE_BITS-1:0] frame_age_reg, mode_age_reg;
    logic signed [rcsac_pkg::CMD_W-1:0] prev_fwd_reg, prev_yaw_reg;

    // Work registers
    logic                           axis_sel_reg, below_reg, axes_ok_reg;
    logic [rcsac_pkg::PROD_W-1:0]   num_reg;
    logic [rcsac_pkg::RAW_W-1:0]    span_reg, rem_reg;
    logic [rcsac_pkg::QUO_W-1:0]    lo_reg, quo_reg;
    logic [rcsac_pkg::STEP_W-1:0]   step_reg;
    logic signed [rcsac_pkg::CMD_W-1:0] x_reg, r_reg;

    // Output register
    logic                           out_valid_reg, out_stale_reg;
    logic signed [rcsac_pkg::CMD_W-1:0] out_fwd_reg, out_yaw_reg;

    // Input fields
    rcsac_pkg::op_t              in_op;
    logic [rcsac_pkg::RAW_W-1:0] in_fwd, in_yaw;
    logic                        in_frame_ok, in_mode_manual, in_accept;

    assign in_op          = s_axis_tuser;
    assign in_fwd         = s_axis_tdata[10:0];
    assign in_yaw         = s_axis_tdata[21:11];
    assign in_frame_ok    = s_axis_tdata[22];
    assign in_mode_manual = s_axis_tdata[23];
    assign s_axis_tready  = (state_reg == ST_IDLE);
    assign in_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_yaw_reg, out_fwd_reg};
    assign m_axis_tuser  = out_stale_reg;

    // Freshness, judged on ages before the tick bumps them
    logic mode_ok, axes_ok;
    logic [rcsac_pkg::AGE_BITS-1:0] frame_age_next, mode_age_next;

    assign mode_ok = mode_manual_reg && mode_seen_reg &&
                     (mode_age_reg <= rcsac_pkg::MODE_STALE_TICKS);
    assign axes_ok = frame_valid_reg && (frame_age_reg <= stale_ticks_reg);
    assign frame_age_next = (frame_age_reg == rcsac_pkg::AGE_MAX) ?
                            frame_age_reg : frame_age_reg + 1'b1;
    assign mode_age_next  = (mode_age_reg == rcsac_pkg::AGE_MAX) ?
                            mode_age_reg : mode_age_reg + 1'b1;

    // Offset from center and half span of the selected axis
    logic [rcsac_pkg::RAW_W-1:0]  raw_sel, diff, span_eff;
    logic                         above;
    logic signed [rcsac_pkg::RAW_W:0] span_raw;
    logic [rcsac_pkg::PROD_W-1:0] prod;

    assign raw_sel  = axis_sel_reg ? yaw_sample_reg : fwd_sample_reg;
    assign above    = (raw_sel >= raw_center_reg);
    assign diff     = above ? (raw_sel - raw_center_reg) : (raw_center_reg - raw_sel);
    assign span_raw = above ?
                      $signed({1'b0, raw_max_reg} - {1'b0, raw_center_reg}) :
                      $signed({1'b0, raw_center_reg} - {1'b0, raw_min_reg});
    assign span_eff = (span_raw <= 0) ? 11'd1 : span_raw[rcsac_pkg::RAW_W-1:0];
    assign prod     = {10'b0, diff} * {11'b0, rcsac_pkg::CMD_FULL};

    // Quotient of 1024 or more saturates the command
    logic quo_ovf;
    assign quo_ovf = (num_reg >= {span_reg, 10'b0});

    // One restoring-division step
    logic [rcsac_pkg::RAW_W:0]   trial, trial_diff;
    logic                        fits;
    logic [rcsac_pkg::RAW_W-1:0] rem_next;

    assign trial      = {rem_reg, lo_reg[rcsac_pkg::QUO_W-1]};
    assign trial_diff = trial - {1'b0, span_reg};
    assign fits       = (trial >= {1'b0, span_reg});
    assign rem_next   = fits ? trial_diff[rcsac_pkg::RAW_W-1:0] : trial[rcsac_pkg::RAW_W-1:0];

    // Clamp, deadband and sign
    logic [rcsac_pkg::QUO_W-1:0]  mag_clamped, mag;
    logic [rcsac_pkg::DB_W-1:0]   db_sel;
    logic                         negate;
    logic signed [rcsac_pkg::CMD_W-1:0] axis_val;

    assign mag_clamped = (quo_reg > rcsac_pkg::CMD_FULL) ? rcsac_pkg::CMD_FULL : quo_reg;
    assign db_sel      = axis_sel_reg ? yaw_db_reg : fwd_db_reg;
    assign mag         = (mag_clamped < db_sel) ? '0 : mag_clamped;
    assign negate      = below_reg ^ (axis_sel_reg ? invert_reg[1] : invert_reg[0]);
    assign axis_val    = negate ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // Slew limit against the previous commands
    logic signed [rcsac_pkg::CMD_W+1:0] step_s, fwd_lo, fwd_hi, yaw_lo, yaw_hi, x_w, r_w;
    logic signed [rcsac_pkg::CMD_W-1:0] x_slew, r_slew;
    logic                               out_free;

    assign step_s = $signed({2'b00, slew_reg});
    assign fwd_lo = 13'(prev_fwd_reg) - step_s;
    assign fwd_hi = 13'(prev_fwd_reg) + step_s;
    assign yaw_lo = 13'(prev_yaw_reg) - step_s;
    assign yaw_hi = 13'(prev_yaw_reg) + step_s;
    assign x_w    = 13'(x_reg);
    assign r_w    = 13'(r_reg);
    assign x_slew = (slew_reg == '0) ? x_reg :
                    (x_w < fwd_lo) ? fwd_lo[rcsac_pkg::CMD_W-1:0] :
                    (x_w > fwd_hi) ? fwd_hi[rcsac_pkg::CMD_W-1:0] : x_reg;
    assign r_slew = (slew_reg == '0) ? r_reg :
                    (r_w < yaw_lo) ? yaw_lo[rcsac_pkg::CMD_W-1:0] :
                    (r_w > yaw_hi) ? yaw_hi[rcsac_pkg::CMD_W-1:0] : r_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_min_reg     <= rcsac_pkg::RST_RAW_MIN;
            raw_center_reg  <= rcsac_pkg::RST_RAW_CENTER;
            raw_max_reg     <= rcsac_pkg::RST_RAW_MAX;
            fwd_db_reg      <= rcsac_pkg::RST_FWD_DB;
            yaw_db_reg      <= rcsac_pkg::RST_YAW_DB;
            invert_reg      <= rcsac_pkg::RST_INVERT;
            slew_reg        <= rcsac_pkg::RST_SLEW;
            stale_ticks_reg <= rcsac_pkg::RST_STALE_TICKS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rcsac_pkg::REG_RAW_MIN:     raw_min_reg     <= cfg_wr_data;
                rcsac_pkg::REG_RAW_CENTER:  raw_center_reg  <= cfg_wr_data;
                rcsac_pkg::REG_RAW_MAX:     raw_max_reg     <= cfg_wr_data;
                rcsac_pkg::REG_FWD_DB:      fwd_db_reg      <= cfg_wr_data[rcsac_pkg::DB_W-1:0];
                rcsac_pkg::REG_YAW_DB:      yaw_db_reg      <= cfg_wr_data[rcsac_pkg::DB_W-1:0];
                rcsac_pkg::REG_INVERT:      invert_reg      <= cfg_wr_data[1:0];
                rcsac_pkg::REG_SLEW:        slew_reg        <= cfg_wr_data;
                rcsac_pkg::REG_STALE_TICKS: stale_ticks_reg <=
                                                cfg_wr_data[rcsac_pkg::AGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, tracking state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fwd_sample_reg  <= '0;
            yaw_sample_reg  <= '0;
            frame_valid_reg <= 1'b0;
            frame_age_reg   <= '0;
            mode_manual_reg <= 1'b0;
            mode_seen_reg   <= 1'b0;
            mode_age_reg    <= '0;
            prev_fwd_reg    <= '0;
            prev_yaw_reg    <= '0;
            out_valid_reg   <= 1'b0;
            axis_sel_reg    <= 1'b0;
            step_reg        <= '0;
        end else begin
            // load a finished word, else drop the current one once taken
            if (state_reg == ST_SLEW && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (in_op)
                            rcsac_pkg::OP_FRAME: begin
                                if (in_frame_ok) begin
                                    fwd_sample_reg  <= in_fwd;
                                    yaw_sample_reg  <= in_yaw;
                                    frame_valid_reg <= 1'b1;
                                    frame_age_reg   <= '0;
                                end else begin
                                    frame_valid_reg <= 1'b0;
                                end
                            end
                            rcsac_pkg::OP_MODE: begin
                                mode_manual_reg <= in_mode_manual;
                                mode_seen_reg   <= 1'b1;
                                mode_age_reg    <= '0;
                            end
                            rcsac_pkg::OP_TICK: begin
                                frame_age_reg <= frame_age_next;
                                mode_age_reg  <= mode_age_next;
                                axes_ok_reg   <= axes_ok;
                                if (!mode_ok) begin
                                    prev_fwd_reg <= '0;
                                    prev_yaw_reg <= '0;
                                end else if (axes_ok) begin
                                    axis_sel_reg <= 1'b0;
                                    state_reg    <= ST_CALC;
                                end else begin
                                    x_reg     <= '0;
                                    r_reg     <= '0;
                                    state_reg <= ST_SLEW;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CALC: begin
                    num_reg   <= prod;
                    span_reg  <= span_eff;
                    below_reg <= !above;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (quo_ovf) begin
                        quo_reg   <= rcsac_pkg::CMD_FULL;
                        state_reg <= ST_POST;
                    end else begin
                        rem_reg   <= num_reg[rcsac_pkg::PROD_W-1:rcsac_pkg::QUO_W];
                        lo_reg    <= num_reg[rcsac_pkg::QUO_W-1:0];
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    lo_reg   <= {lo_reg[rcsac_pkg::QUO_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[rcsac_pkg::QUO_W-2:0], fits};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == rcsac_pkg::STEP_W'(rcsac_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (!axis_sel_reg) begin
                        x_reg        <= axis_val;
                        axis_sel_reg <= 1'b1;
                        state_reg    <= ST_CALC;
                    end else begin
                        r_reg     <= axis_val;
                        state_reg <= ST_SLEW;
                    end
                end
                ST_SLEW: begin
                    // hold until the output register is free
                    if (out_free) begin
                        prev_fwd_reg  <= x_slew;
                        prev_yaw_reg  <= r_slew;
                        out_fwd_reg   <= x_slew;
                        out_yaw_reg   <= r_slew;
                        out_stale_reg <= !axes_ok_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Remainder stays below the divisor through every division step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    // Commands stay within full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_fwd_reg <= 11'sd1000 && out_fwd_reg >= -11'sd1000 &&
                           out_yaw_reg <= 11'sd1000 && out_yaw_reg >= -11'sd1000))
        else $error("command out of range");

    // A loaded word becomes the slew reference
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLEW && out_free) |=>
            (prev_fwd_reg == out_fwd_reg && prev_yaw_reg == out_yaw_reg && out_valid_reg))
        else $error("slew reference differs from emitted word");

    // Stale axes give zero commands when slew limiting is off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLEW && out_free && !axes_ok_reg && slew_reg == '0) |=>
            (out_fwd_reg == '0 && out_yaw_reg == '0 && out_stale_reg))
        else $error("stale word carries nonzero command");

endmodule
